// File: hdl/lrus_pkg.sv
package lrus_pkg;

  localparam int unsigned PageW        = 16;
  localparam int unsigned FramesW      = 5;
  localparam int unsigned DepthW       = 4;
  localparam int unsigned CountW       = 16;
  localparam int unsigned MaxFramesDef = 16;

  localparam logic [FramesW-1:0] FramesRst = FramesW'(4);
  localparam logic [CountW-1:0]  CountMax  = {CountW{1'b1}};

  typedef struct packed {
    logic [PageW-1:0] page_number;
    logic             last_reference;
  } lrus_req_t;

  typedef struct packed {
    logic              hit;
    logic [DepthW-1:0] hit_depth;
    logic              replaced;
    logic [PageW-1:0]  evicted_page;
    logic [CountW-1:0] replacement_count;
  } lrus_rsp_t;

  // Per-item control seen by every cell of the stack
  typedef struct packed {
    logic update;
    logic hit;
  } lrus_ctrl_t;

endpackage

// File: hdl/lrus_cell.sv
module lrus_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                          clk_i,
  input  lrus_pkg::lrus_ctrl_t          ctrl_i,
  input  logic [lrus_pkg::PageW-1:0]    page_i,
  input  logic [lrus_pkg::PageW-1:0]    prev_i,
  input  logic [CNT_W-1:0]              fill_i,
  input  logic [CNT_W-1:0]              limit_i,
  input  logic                          found_i,
  output logic                          found_o,
  output logic                          match_o,
  output logic [lrus_pkg::PageW-1:0]    page_o
);
  import lrus_pkg::*;

  logic [PageW-1:0] page_q;
  logic [PageW-1:0] page_d;
  logic             valid;
  logic             load;
  logic [PageW-1:0] src;

  assign valid   = CNT_W'(IDX) < fill_i;
  assign match_o = valid && (page_q == page_i);
  assign found_o = found_i | match_o;

  // The top cell takes the new page, every other cell its upper neighbor
  assign src = (IDX == 0) ? page_i : prev_i;

  // On a hit, shift down to and including the hit cell; on a miss, up to the limit
  assign load = ctrl_i.update && (ctrl_i.hit ? !found_i : (CNT_W'(IDX) <= limit_i));

  always_comb begin
    page_d = page_q;
    if (load) begin
      page_d = src;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign page_o = page_q;

endmodule

// File: hdl/lru_stack_page_replacement.sv
// LRU stack of page frames, one page reference per item.
// Command channel: an item (req_i) is taken at a rising edge with start_i high
// and busy_o low. busy_o stays low: an item can be issued every cycle.
// Result channel: one result per item on result_o, marked by result_valid_o,
// in the cycle after the item is taken and held for exactly that cycle. The
// receiver cannot stall; the result must be captured when the strobe is high.
// Throughput is 1 item per cycle, set by the row of stack cells, which all
// compare against the page and shift in the same cycle.
// Configuration: cfg_we_i writes cfg_wdata_i into the frame count register
// (reset 4); write it only while no item is in flight. A count of zero acts
// as one, a count above MAX_FRAMES as MAX_FRAMES.
// Reset (rst_ni low, asynchronous) empties the stack and clears the
// replacement counter; no clearing pass is needed. An item with
// last_reference set empties the stack and counter after its own result.
module lru_stack_page_replacement #(
  parameter int unsigned MAX_FRAMES = lrus_pkg::MaxFramesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  lrus_pkg::lrus_req_t             req_i,
  output logic                            busy_o,
  output logic                            result_valid_o,
  output lrus_pkg::lrus_rsp_t             result_o,
  input  logic                            cfg_we_i,
  input  logic [lrus_pkg::FramesW-1:0]    cfg_wdata_i
);
  import lrus_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic [FramesW-1:0] frames_q;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [CountW-1:0]  count_q, count_d, count_new;
  logic               valid_q;
  lrus_rsp_t          result_q, result_d;

  logic               accept;
  logic [CNT_W-1:0]   frames_eff;
  logic [CNT_W-1:0]   limit;
  logic [IDX_W-1:0]   hit_pos;
  logic               full;
  lrus_ctrl_t         ctrl;

  logic [MAX_FRAMES:0]   found;
  logic [MAX_FRAMES-1:0] match;
  logic [PageW-1:0]      pages [MAX_FRAMES];

  function automatic logic cfg_wdata_zero(input logic [FramesW-1:0] v);
    return v == '0;
  endfunction

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;

  always_comb begin
    if (cfg_wdata_zero(frames_q)) begin
      frames_eff = CNT_W'(1);
    end else if (32'(frames_q) > MAX_FRAMES) begin
      frames_eff = CNT_W'(MAX_FRAMES);
    end else begin
      frames_eff = CNT_W'(frames_q);
    end
  end

  assign full     = fill_q >= frames_eff;
  assign ctrl     = '{update: accept, hit: found[MAX_FRAMES]};
  assign limit    = full ? (frames_eff - CNT_W'(1)) : fill_q;
  assign found[0] = 1'b0;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    logic [PageW-1:0] prev;
    if (g == 0) begin : g_top
      assign prev = req_i.page_number;
    end else begin : g_below
      assign prev = pages[g-1];
    end
    lrus_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .page_i  (req_i.page_number),
      .prev_i  (prev),
      .fill_i  (fill_q),
      .limit_i (limit),
      .found_i (found[g]),
      .found_o (found[g+1]),
      .match_o (match[g]),
      .page_o  (pages[g])
    );
  end

  // First match from the top wins
  always_comb begin
    hit_pos = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_pos = IDX_W'(i);
      end
    end
  end

  assign count_new = (count_q != CountMax) ? count_q + CountW'(1) : count_q;

  always_comb begin
    fill_d   = fill_q;
    count_d  = count_q;
    result_d = '0;
    result_d.hit = ctrl.hit;
    if (ctrl.hit) begin
      result_d.hit_depth = DepthW'(hit_pos);
    end else if (!full) begin
      fill_d = fill_q + CNT_W'(1);
    end else begin
      fill_d                = frames_eff;
      count_d               = count_new;
      result_d.replaced     = 1'b1;
      result_d.evicted_page = pages[IDX_W'(fill_q - CNT_W'(1))];
    end
    result_d.replacement_count = count_d;
    if (req_i.last_reference) begin
      fill_d  = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FramesRst;
      fill_q   <= '0;
      count_q  <= '0;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frames_q <= cfg_wdata_i;
      end
      if (accept) begin
        fill_q  <= fill_d;
        count_q <= count_d;
      end
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

// File: hdl/lrus_checker.sv
module lrus_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic                 result_valid_o,
  input lrus_pkg::lrus_rsp_t  result_o
);
  import lrus_pkg::*;

  // One result per taken item, in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> result_valid_o)
    else $error("item taken without a result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !result_valid_o)
    else $error("result without an item");

  a_miss_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.hit |-> result_o.hit_depth == '0)
    else $error("depth reported on a miss");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.hit |-> !result_o.replaced && result_o.evicted_page == '0)
    else $error("eviction on a hit");

  a_evict_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.replaced |-> result_o.replacement_count != '0)
    else $error("replacement not counted");

endmodule

bind lru_stack_page_replacement lrus_checker u_lrus_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
